// ----- hw/rtl/rmts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmts_pkg
// Shared widths, constants, stage-enable type and the xorshift64 step of the
// multinomial token sampler.
// ----------------------------------------------------------------------------
package rmts_pkg;

	localparam int PROB_W = 25;
	localparam int SUM_W  = 26;
	localparam int COIN_W = 24;
	localparam int TOK_W  = 16;
	localparam int RNG_W  = 64;

	localparam logic [SUM_W-1:0] SUM_CAP    = 26'h200_0000;
	localparam logic [RNG_W-1:0] XS_MULT    = 64'h2545_F491_4F6C_DD1D;
	localparam logic [RNG_W-1:0] SEED_RESET = 64'd1;

	// load enables of the coin pipeline, one per stage
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

	function automatic logic [RNG_W-1:0] xs_advance(input logic [RNG_W-1:0] x);
		logic [RNG_W-1:0] a;
		logic [RNG_W-1:0] b;
		logic [RNG_W-1:0] c;
		a = x ^ (x >> 12);
		b = a ^ (a << 25);
		c = b ^ (b >> 27);
		return c;
	endfunction

endpackage

// ----- hw/rtl/rmts_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmts_if
// Valid/ready channels of the sampler: probability items, token results and
// the seed write port.
// ----------------------------------------------------------------------------
interface rmts_sample_if import rmts_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [PROB_W-1:0] prob;
	logic              last;

	modport source (output valid, output prob, output last, input ready);
	modport sink   (input valid, input prob, input last, output ready);
endinterface

interface rmts_token_if import rmts_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [TOK_W-1:0] token_index;

	modport source (output valid, output token_index, input ready);
	modport sink   (input valid, input token_index, output ready);
endinterface

interface rmts_cfg_if import rmts_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [RNG_W-1:0] seed;

	modport source (output valid, output seed, input ready);
	modport sink   (input valid, input seed, output ready);
endinterface

// ----- hw/rtl/rmts_coin_pipe.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmts_coin_pipe
// Output scrambler of xorshift64*: low 64 bits of x * XS_MULT, built from
// three 32x32 products over three stages; keeps product bits [63:40].
// ----------------------------------------------------------------------------
module rmts_coin_pipe import rmts_pkg::*; (
	input  logic              clk,
	input  stage_en_t         en,
	input  logic [RNG_W-1:0]  x,
	output logic [COIN_W-1:0] coin
);

	localparam logic [31:0] MULT_LO = XS_MULT[31:0];
	localparam logic [31:0] MULT_HI = XS_MULT[63:32];

	logic [RNG_W-1:0]  x_s1;
	logic [31:0]       p0_hi_s2;
	logic [31:0]       x_hi_s2;
	logic [31:0]       x_lo_s2;
	logic [31:0]       acc_s3;
	logic [31:0]       x_lo_s3;
	logic [COIN_W-1:0] coin_s4;

	logic [63:0] p0;
	logic [31:0] p1;
	logic [31:0] p2;
	logic [31:0] sum3;

	always_comb begin
		p0   = 64'(x_s1[31:0]) * 64'(MULT_LO);
		p1   = x_hi_s2 * MULT_LO;
		p2   = x_lo_s3 * MULT_HI;
		sum3 = acc_s3 + p2;
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			x_s1 <= x;
		end
		if (en.s2) begin
			p0_hi_s2 <= p0[63:32];
			x_hi_s2  <= x_s1[63:32];
			x_lo_s2  <= x_s1[31:0];
		end
		if (en.s3) begin
			acc_s3  <= p0_hi_s2 + p1;
			x_lo_s3 <= x_lo_s2;
		end
		if (en.s4) begin
			coin_s4 <= sum3[31:8];
		end
	end

	assign coin = coin_s4;

endmodule

// ----- hw/rtl/random_multinomial_token_sampler_unit.sv -----
`timescale 1ns / 1ps
// The last item passes stages s1 to s4, then token_index is registered as valid.
// Throughput: one item per cycle unless stalled; each stage stalls only when the
// stage after it is full, so bubbles collapse under output back-pressure.
// The coin multiply (three 32x32 products) sets the depth of the pipeline.
// Reset (arst_n low): pipeline empty, generator word back to 1, no vector open.
// ----------------------------------------------------------------------------
// random_multinomial_token_sampler_unit
// Streams token probabilities, draws one xorshift64* coin per vector and
// returns the first index whose cumulative sum exceeds the coin, else the last one.
// ----------------------------------------------------------------------------
module random_multinomial_token_sampler_unit import rmts_pkg::*; #(
	parameter int VOCAB_MAX = 65536
) (
	input  logic          clk,
	input  logic          arst_n,
	rmts_sample_if.sink   samples,
	rmts_token_if.source  tokens,
	rmts_cfg_if.sink      cfg
);

	localparam int CNT_W = $clog2(VOCAB_MAX);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(VOCAB_MAX - 1);

	// ---------------- front: generator, running sum, index ----------------
	logic [RNG_W-1:0] rng_q;
	logic             in_vec_q;
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;

	// ---------------- pipeline control ----------------
	logic v1_s1, v2_s2, v3_s3, v4_s4;
	logic r1, r2, r3, r4;
	logic m1, m2, m3, m4, m5;
	logic out_free;

	// ---------------- per-item payload along the pipe ----------------
	logic [SUM_W-1:0] sum_s1, sum_s2, sum_s3, sum_s4;
	logic [CNT_W-1:0] idx_s1, idx_s2, idx_s3, idx_s4;
	logic             first_s1, first_s2, first_s3, first_s4;
	logic             last_s1, last_s2, last_s3, last_s4;

	// ---------------- back end: vector selection state ----------------
	logic [COIN_W-1:0] coin_q;
	logic              found_q;
	logic [CNT_W-1:0]  chosen_q;
	logic              out_valid_q;
	logic [TOK_W-1:0]  out_index_q;

	logic              first_in;
	logic [RNG_W-1:0]  rng_next;
	logic [SUM_W:0]    sum_raw;
	logic [SUM_W-1:0]  sum_in;
	logic [CNT_W-1:0]  idx_in;

	logic [COIN_W-1:0] coin_new;
	logic [COIN_W-1:0] coin_use;
	logic              found_cur;
	logic [CNT_W-1:0]  chosen_cur;
	logic              hit;
	logic              found_nxt;
	logic [CNT_W-1:0]  chosen_nxt;
	logic [31:0]       pick_wide;

	stage_en_t         coin_en;

	// Front-end arithmetic: open a vector on the first item, add with
	// saturation at 2.0, and number the item.
	always_comb begin
		first_in = !in_vec_q;
		rng_next = xs_advance(rng_q);
		sum_raw  = (first_in ? (SUM_W+1)'(0) : {1'b0, sum_q}) + (SUM_W+1)'(samples.prob);
		sum_in   = (sum_raw > {1'b0, SUM_CAP}) ? SUM_CAP : sum_raw[SUM_W-1:0];
		idx_in   = first_in ? '0 : cnt_q;
	end

	// Ready chain: a stage takes a new item when empty or when its item
	// moves on. Only last items need the output register.
	always_comb begin
		out_free = !out_valid_q || tokens.ready;
		r4 = !v4_s4 || !last_s4 || out_free;
		r3 = !v3_s3 || r4;
		r2 = !v2_s2 || r3;
		r1 = !v1_s1 || r2;
		m1 = samples.valid && r1;
		m2 = v1_s1 && r2;
		m3 = v2_s2 && r3;
		m4 = v3_s3 && r4;
		m5 = v4_s4 && r4;
	end

	assign samples.ready = r1;
	assign cfg.ready     = 1'b1;

	always_comb begin
		coin_en.s1 = m1;
		coin_en.s2 = m2;
		coin_en.s3 = m3;
		coin_en.s4 = m4;
	end

	rmts_coin_pipe u_coin (
		.clk  (clk),
		.en   (coin_en),
		.x    (rng_next),
		.coin (coin_new)
	);

	// Back-end decision: the first item of a vector brings its own coin and
	// clears the search; later items reuse the held coin.
	always_comb begin
		coin_use   = first_s4 ? coin_new : coin_q;
		found_cur  = first_s4 ? 1'b0 : found_q;
		chosen_cur = first_s4 ? '0 : chosen_q;
		hit        = !found_cur && ({2'b00, coin_use} < sum_s4);
		found_nxt  = found_cur || hit;
		chosen_nxt = hit ? idx_s4 : chosen_cur;
		pick_wide  = 32'(found_nxt ? chosen_nxt : idx_s4);
	end

	// Control and state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rng_q       <= SEED_RESET;
			in_vec_q    <= 1'b0;
			sum_q       <= '0;
			cnt_q       <= '0;
			v1_s1       <= 1'b0;
			v2_s2       <= 1'b0;
			v3_s3       <= 1'b0;
			v4_s4       <= 1'b0;
			coin_q      <= '0;
			found_q     <= 1'b0;
			chosen_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// seed write loads the generator; a coin already drawn is kept
			if (cfg.valid) begin
				rng_q <= cfg.seed;
			end else if (m1 && first_in) begin
				rng_q <= rng_next;
			end

			if (m1) begin
				in_vec_q <= !samples.last;
				sum_q    <= sum_in;
				cnt_q    <= (idx_in < CNT_MAX) ? idx_in + CNT_W'(1) : idx_in;
			end

			// advance valid bits
			if (m1) begin
				v1_s1 <= 1'b1;
			end else if (m2) begin
				v1_s1 <= 1'b0;
			end
			if (m2) begin
				v2_s2 <= 1'b1;
			end else if (m3) begin
				v2_s2 <= 1'b0;
			end
			if (m3) begin
				v3_s3 <= 1'b1;
			end else if (m4) begin
				v3_s3 <= 1'b0;
			end
			if (m4) begin
				v4_s4 <= 1'b1;
			end else if (m5) begin
				v4_s4 <= 1'b0;
			end

			if (m5) begin
				coin_q   <= coin_use;
				found_q  <= found_nxt;
				chosen_q <= chosen_nxt;
			end

			// hold the result until taken; drop it once delivered
			if (m5 && last_s4) begin
				out_valid_q <= 1'b1;
			end else if (tokens.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers, no reset.
	always_ff @(posedge clk) begin
		if (m1) begin
			sum_s1   <= sum_in;
			idx_s1   <= idx_in;
			first_s1 <= first_in;
			last_s1  <= samples.last;
		end
		if (m2) begin
			sum_s2   <= sum_s1;
			idx_s2   <= idx_s1;
			first_s2 <= first_s1;
			last_s2  <= last_s1;
		end
		if (m3) begin
			sum_s3   <= sum_s2;
			idx_s3   <= idx_s2;
			first_s3 <= first_s2;
			last_s3  <= last_s2;
		end
		if (m4) begin
			sum_s4   <= sum_s3;
			idx_s4   <= idx_s3;
			first_s4 <= first_s3;
			last_s4  <= last_s3;
		end
		if (m5 && last_s4) begin
			out_index_q <= pick_wide[TOK_W-1:0];
		end
	end

	assign tokens.valid       = out_valid_q;
	assign tokens.token_index = out_index_q;

endmodule

// ----- tb/tb_random_multinomial_token_sampler_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_random_multinomial_token_sampler_unit
// Self-checking bench for the multinomial token sampler: streams probability
// vectors, models the xorshift64* coin and the cumulative-sum pick in step
// with every accepted item, and checks each returned token index in order.
// ----------------------------------------------------------------------------
module tb_random_multinomial_token_sampler_unit;
	import rmts_pkg::*;

	localparam int VOCAB   = 65536;
	localparam int SETTLE  = 10;        // idle margin after the last token is back
	localparam int RAND_N  = 800;       // random probabilities to stream
	localparam int CALM_AT = 680;       // no idling beyond this many

	typedef enum logic {ROW_PROB, ROW_SEED} row_kind_t;

	// One line of the directed plan: either a seed load, or a run of 'count'
	// equal probabilities, the final one flagged last when 'last' is set.
	// Where 'fixed' is set the vector ends here with a token known by hand.
	typedef struct packed {
		row_kind_t         kind;
		logic [RNG_W-1:0]  seed;
		logic [PROB_W-1:0] prob;
		logic [16:0]       count;
		logic              last;
		logic              fixed;
		logic [TOK_W-1:0]  token;
	} plan_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	rmts_sample_if prob_ch ();
	rmts_token_if  tok_ch ();
	rmts_cfg_if    seed_ch ();

	random_multinomial_token_sampler_unit #(
		.VOCAB_MAX(VOCAB)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (prob_ch),
		.tokens  (tok_ch),
		.cfg     (seed_ch)
	);

	always #10 clk = ~clk;

	// Mirror of the sampler state, advanced on every accepted item.
	logic [RNG_W-1:0]  gen_word;
	logic [COIN_W-1:0] coin;
	logic [SUM_W-1:0]  cum_sum;
	int                slot;
	int                pick;
	logic              picked;
	logic              vec_open;

	// Tokens owed by the block, oldest first.
	logic [TOK_W-1:0] owed_tokens[$];

	logic              calm = 1'b0;
	int                errors = 0;
	int                n_items = 0;
	int                n_vectors = 0;
	int                n_seeds = 0;
	int                n_checked = 0;
	int                longest = 0;
	int                vec_len = 0;
	logic [TOK_W-1:0]  want;
	plan_row_t         plan[$];

	function automatic plan_row_t prob_row(input logic [PROB_W-1:0] p, input int cnt,
			input logic l, input logic fixed, input logic [TOK_W-1:0] tok);
		plan_row_t r;
		r = '0;
		r.kind  = ROW_PROB;
		r.prob  = p;
		r.count = 17'(cnt);
		r.last  = l;
		r.fixed = fixed;
		r.token = tok;
		return r;
	endfunction

	function automatic plan_row_t seed_row(input logic [RNG_W-1:0] s);
		plan_row_t r;
		r = '0;
		r.kind = ROW_SEED;
		r.seed = s;
		return r;
	endfunction

	// Advance the mirror by one probability; flag a token on the last item.
	task automatic predict_token(input logic [PROB_W-1:0] p, input logic l,
			output logic fire, output logic [TOK_W-1:0] tok);
		logic [RNG_W-1:0] x;
		logic [RNG_W-1:0] prod;
		logic [SUM_W-1:0] grown;
		fire = 1'b0;
		tok  = '0;
		// first item of a vector: step the generator and draw a fresh coin
		if (!vec_open) begin
			x = gen_word;
			x = x ^ (x >> 12);
			x = x ^ (x << 25);
			x = x ^ (x >> 27);
			gen_word = x;
			prod     = x * XS_MULT;
			coin     = prod[63:40];
			cum_sum  = '0;
			slot     = 0;
			pick     = 0;
			picked   = 1'b0;
			vec_open = 1'b1;
		end
		// accumulate, clamped at 2.0
		grown   = cum_sum + {1'b0, p};
		cum_sum = (grown > SUM_CAP) ? SUM_CAP : grown;
		// note the first slot where the coin falls strictly below the sum
		if (!picked && ({2'b00, coin} < cum_sum)) begin
			pick   = slot;
			picked = 1'b1;
		end
		if (l) begin
			fire     = 1'b1;
			tok      = picked ? pick[TOK_W-1:0] : slot[TOK_W-1:0];
			vec_open = 1'b0;
		end else if (slot < VOCAB - 1) begin
			slot++;
		end
	endtask

	// Offer one probability, with an occasional idle burst ahead of it. On
	// return the item has just been taken at a rising edge and valid is
	// still high; whoever acts next on the channel must drop or reuse it.
	task automatic push_prob(input logic [PROB_W-1:0] p, input logic l,
			input logic fixed, input logic [TOK_W-1:0] tok);
		logic             fire;
		logic [TOK_W-1:0] guess;
		@(negedge clk);
		if (!calm && $urandom_range(0, 5) == 0) begin
			prob_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		prob_ch.valid <= 1'b1;
		prob_ch.prob  <= p;
		prob_ch.last  <= l;
		@(posedge clk);
		while (!prob_ch.ready) @(posedge clk);
		predict_token(p, l, fire, guess);
		n_items++;
		vec_len++;
		if (fire) begin
			owed_tokens.push_back(fixed ? tok : guess);
			n_vectors++;
			if (vec_len > longest)
				longest = vec_len;
			vec_len = 0;
		end
	endtask

	// Hold the sender until every owed token is back, then let the pipe settle.
	task automatic drain_tokens();
		@(negedge clk);
		prob_ch.valid <= 1'b0;
		while (owed_tokens.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Load a new seed while the block is idle; the mirror takes it at once.
	task automatic load_seed(input logic [RNG_W-1:0] s);
		drain_tokens();
		seed_ch.valid <= 1'b1;
		seed_ch.seed  <= s;
		@(posedge clk);
		while (!seed_ch.ready) @(posedge clk);
		gen_word = s;
		n_seeds++;
		@(negedge clk);
		seed_ch.valid <= 1'b0;
	endtask

	// One random vector: mostly well-formed distributions near 1.0 in total,
	// the rest raw noise, sparse vectors and a mix of extreme values.
	task automatic stream_random_vector();
		int                n;
		int                style;
		int                cap;
		logic [PROB_W-1:0] p;
		style = $urandom_range(0, 9);
		n     = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
		cap   = ((1 << 25) - 1) / n;
		for (int i = 0; i < n; i++) begin
			case (style)
				0, 1, 2, 3, 4, 5, 6: p = PROB_W'($urandom_range(0, cap));
				7: p = PROB_W'($urandom_range(0, (1 << 25) - 1));
				8: p = ($urandom_range(0, 3) == 0) ?
					PROB_W'($urandom_range(1, 1 << 24)) : '0;
				default: begin
					case ($urandom_range(0, 4))
						0: p = '0;
						1: p = PROB_W'(1);
						2: p = 25'h0FF_FFFF;
						3: p = 25'h100_0000;
						default: p = '1;
					endcase
				end
			endcase
			push_prob(p, i == n - 1, 1'b0, '0);
		end
	endtask

	// Compare every accepted token with the oldest one owed.
	always @(posedge clk) begin
		if (arst_n && tok_ch.valid && tok_ch.ready) begin
			if (owed_tokens.size() == 0) begin
				$display("%0t: token_index %0d arrived with none expected",
					$time, tok_ch.token_index);
				errors++;
			end else begin
				want = owed_tokens.pop_front();
				n_checked++;
				if (tok_ch.token_index !== want) begin
					$display("%0t: token_index expected %0d, got %0d",
						$time, want, tok_ch.token_index);
					errors++;
				end
			end
		end
	end

	// Result side: ready mostly high, dropped for random bursts until calm.
	initial begin
		tok_ch.ready = 1'b1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				tok_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end
			tok_ch.ready <= 1'b1;
			repeat ($urandom_range(0, 12)) @(negedge clk);
		end
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#4_000_000;
		$display("tb_random_multinomial_token_sampler_unit NOT OK");
		$finish;
	end

	initial begin
		int               base;
		int               pick_seed;
		logic [RNG_W-1:0] s;
		plan_row_t        r;

		prob_ch.valid = 1'b0;
		prob_ch.prob  = '0;
		prob_ch.last  = 1'b0;
		seed_ch.valid = 1'b0;
		seed_ch.seed  = '0;

		gen_word = SEED_RESET;
		coin     = '0;
		cum_sum  = '0;
		slot     = 0;
		pick     = 0;
		picked   = 1'b0;
		vec_open = 1'b0;

		// Directed plan. Fixed tokens are the ones that follow from the
		// rules alone: a single-item vector picks 0; with a zero seed the
		// coin is 0, so the first nonzero probability wins and an all-zero
		// vector falls back to its last slot; a first probability of 1.0 or
		// more always beats the coin.
		plan.push_back(prob_row(25'd0, 1, 1'b1, 1'b1, 16'd0));           // reset seed, one item
		plan.push_back(seed_row(64'd0));                                 // stuck generator
		plan.push_back(prob_row(25'd0, 2, 1'b0, 1'b0, '0));
		plan.push_back(prob_row(25'h155, 1, 1'b0, 1'b0, '0));
		plan.push_back(prob_row(25'd0, 1, 1'b1, 1'b1, 16'd2));           // first nonzero wins
		plan.push_back(prob_row(25'd0, 1, 1'b0, 1'b0, '0));
		plan.push_back(prob_row(25'd0, 1, 1'b1, 1'b1, 16'd1));           // never hit: last slot
		plan.push_back(prob_row(25'h1FF_FFFF, 1, 1'b1, 1'b1, 16'd0));    // above 1.0 alone
		plan.push_back(seed_row(64'hFFFF_FFFF_FFFF_FFFF));
		plan.push_back(prob_row(25'h1FF_FFFF, 2, 1'b0, 1'b0, '0));        // sum clamps at 2.0
		plan.push_back(prob_row(25'h100_0000, 1, 1'b1, 1'b1, 16'd0));
		plan.push_back(prob_row(25'h080_0000, 1, 1'b0, 1'b0, '0));
		plan.push_back(prob_row(25'h080_0000, 1, 1'b1, 1'b0, '0));
		plan.push_back(seed_row(64'h9E37_79B9_7F4A_7C15));
		plan.push_back(prob_row(25'd1, 3, 1'b0, 1'b0, '0));
		plan.push_back(prob_row(25'h0FF_FFFF, 1, 1'b1, 1'b0, '0));
		plan.push_back(prob_row(25'h0AA_AAAA, 1, 1'b0, 1'b0, '0));
		plan.push_back(prob_row(25'h155_5555, 1, 1'b0, 1'b0, '0));
		plan.push_back(prob_row(25'd0, 1, 1'b1, 1'b0, '0));
		plan.push_back(seed_row(64'h8000_0000_0000_0000));
		plan.push_back(prob_row(25'h040_0000, 4, 1'b0, 1'b0, '0));
		plan.push_back(prob_row(25'h040_0000, 1, 1'b1, 1'b0, '0));
		// longer all-zero vector under a zero seed: falls back to its last slot
		plan.push_back(seed_row(64'd0));
		plan.push_back(prob_row(25'd0, 30, 1'b0, 1'b0, '0));
		plan.push_back(prob_row(25'd0, 1, 1'b1, 1'b1, 16'd30));

		// Hold reset, then release it away from the rising edge.
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// Walk the plan.
		foreach (plan[i]) begin
			r = plan[i];
			if (r.kind == ROW_SEED) begin
				load_seed(r.seed);
			end else begin
				for (int k = 0; k < r.count; k++)
					push_prob(r.prob, r.last && (k == r.count - 1), r.fixed, r.token);
			end
		end

		// Random part: reseed now and then between vectors (corner seeds
		// included), and sometimes just hold the sender until the block is
		// empty. The tail runs with no idling on either side.
		load_seed({$urandom, $urandom});
		base = n_items;
		while (n_items - base < RAND_N) begin
			if (n_items - base > CALM_AT)
				calm = 1'b1;
			if ($urandom_range(0, 9) == 0) begin
				pick_seed = $urandom_range(0, 9);
				case (pick_seed)
					0: s = '0;
					1: s = '1;
					default: s = {$urandom, $urandom};
				endcase
				load_seed(s);
			end else if ($urandom_range(0, 19) == 0) begin
				drain_tokens();
			end
			stream_random_vector();
		end

		// Drop valid, collect every owed token, then let the pipe settle.
		drain_tokens();

		$display("streamed %0d probabilities in %0d vectors (longest %0d), %0d seed loads",
			n_items, n_vectors, longest, n_seeds);
		$display("checked %0d token indexes, %0d mismatches", n_checked, errors);
		if (errors == 0)
			$display("tb_random_multinomial_token_sampler_unit OK");
		else
			$display("tb_random_multinomial_token_sampler_unit NOT OK");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/rmts_pkg.sv
hw/rtl/rmts_if.sv
hw/rtl/rmts_coin_pipe.sv
hw/rtl/random_multinomial_token_sampler_unit.sv
tb/tb_random_multinomial_token_sampler_unit.sv
